FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the address region table checker.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property check, disabled while rst is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never hold at a clock edge.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

FILE: src/arc_pkg.sv
// Shared constants, types and codes for the address region table checker.
// No dependencies; used by every module of the block but arc_ram.
`timescale 1ns / 1ps

package arc_pkg;

   localparam int ADDR_W      = 32;
   localparam int MAX_REGIONS = 16;
   localparam int PAGE_SHIFT  = 12;
   localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int ENTRY_W     = 2 * ADDR_W + 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // page mask on the widened map sum, page size on a 33-bit address
   localparam logic [ADDR_W+1:0] PAGE_MASK = ((ADDR_W+2)'(1) << PAGE_SHIFT) - (ADDR_W+2)'(1);
   localparam logic [ADDR_W:0]   PAGE_SIZE = (ADDR_W+1)'(1) << PAGE_SHIFT;

   localparam int FB_READ  = 0;
   localparam int FB_WRITE = 1;
   localparam int FB_EXEC  = 2;
   localparam int FB_STACK = 3;

   localparam int EC_PRESENT = 0;
   localparam int EC_WRITE   = 1;

   localparam logic [2:0] PERM_USER  = 3'd4;
   localparam logic [2:0] PERM_WRITE = 3'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   localparam logic [0:0] CSR_BASE_IDX = 1'b0;
   localparam logic [0:0] CSR_TOP_IDX  = 1'b1;

   localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0020_0000;
   localparam logic [ADDR_W-1:0] TOP_RESET  = 32'hB000_0000;

   typedef enum logic [1:0] {
      KIND_MAP   = 2'd0,
      KIND_FIND  = 2'd1,
      KIND_FAULT = 2'd2,
      KIND_RANGE = 2'd3
   } arc_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_PUT
   } arc_state_type;

   // classified item handed from the front to the back
   typedef struct packed {
      arc_kind_type      kind;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] map_start;
      logic [ADDR_W-1:0] map_end;
      logic [ADDR_W:0]   range_end;
      logic              ok;
      logic [3:0]        flags;
      logic [2:0]        fault_code;
      logic              write_access;
   } arc_job_type;

endpackage

FILE: src/address_region_table_checker.sv
// Top level of the address region table checker: front end, item queue and
// back end. Uses arc_pkg, arc_front, arc_fifo and arc_back.
//
//   port group   direction   handshake            carries
//   req_*        in          req_valid/req_stall  map, find, fault, range item
//   rsp_*        out         rsp_valid/rsp_stall  one result item per request
//   csr_*        in          csr_write_enable     user-space base and top
//
// An item is popped, then scanned with one registered RAM read per stored entry,
// and finished with a result; find, fault and range stop early at their decision.
// A map that inserts then moves entries up one at a time and writes the new
// entry.
// Reset is synchronous; the table contents need no clearing, only the count.
// A result held by rsp_stall holds the back end; the queue takes two items.
`timescale 1ns / 1ps

module address_region_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_addr,
   input  logic [31:0] req_length,
   input  logic [3:0]  req_flags,
   input  logic [2:0]  req_fault_code,
   input  logic        req_write_access,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [31:0] rsp_region_start,
   output logic [31:0] rsp_region_end,
   output logic [3:0]  rsp_region_flags,
   output logic        rsp_allowed,
   output logic [2:0]  rsp_pte_perm,
   output logic [31:0] rsp_fault_count
);

   arc_pkg::arc_job_type front_job;
   arc_pkg::arc_job_type queue_job;
   logic                 queue_full;
   logic                 queue_valid;
   logic                 queue_pop;
   logic                 push;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   arc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_kind         (req_kind),
      .req_addr         (req_addr),
      .req_length       (req_length),
      .req_flags        (req_flags),
      .req_fault_code   (req_fault_code),
      .req_write_access (req_write_access),
      .job              (front_job)
   );

   arc_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (front_job),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_job   (queue_job)
   );

   arc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (queue_valid),
      .job              (queue_job),
      .job_pop          (queue_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_region_start (rsp_region_start),
      .rsp_region_end   (rsp_region_end),
      .rsp_region_flags (rsp_region_flags),
      .rsp_allowed      (rsp_allowed),
      .rsp_pte_perm     (rsp_pte_perm),
      .rsp_fault_count  (rsp_fault_count)
   );

endmodule

FILE: src/arc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module arc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: src/arc_front.sv
// Front end: holds the user-space bound registers, page-rounds map ranges
// and checks map and range items against the bounds. Uses arc_pkg.
`timescale 1ns / 1ps

module arc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [0:0]                csr_index,
   input  logic [31:0]               csr_write_data,
   input  logic [1:0]                req_kind,
   input  logic [31:0]               req_addr,
   input  logic [31:0]               req_length,
   input  logic [3:0]                req_flags,
   input  logic [2:0]                req_fault_code,
   input  logic                      req_write_access,
   output arc_pkg::arc_job_type      job
);

   logic [arc_pkg::ADDR_W-1:0] base_ff;
   logic [arc_pkg::ADDR_W-1:0] top_ff;
   logic [arc_pkg::ADDR_W+1:0] map_sum;
   logic [arc_pkg::ADDR_W+1:0] map_end;
   logic [arc_pkg::ADDR_W-1:0] map_start;
   logic [arc_pkg::ADDR_W:0]   range_end;
   logic                       map_ok;
   logic                       range_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= arc_pkg::BASE_RESET;
         top_ff  <= arc_pkg::TOP_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == arc_pkg::CSR_BASE_IDX) begin
            base_ff <= csr_write_data;
         end
         if (csr_index == arc_pkg::CSR_TOP_IDX) begin
            top_ff <= csr_write_data;
         end
      end
   end

   always_comb begin
      map_start = req_addr & ~arc_pkg::PAGE_MASK[arc_pkg::ADDR_W-1:0];
      map_sum   = {2'b00, req_addr} + {2'b00, req_length} + arc_pkg::PAGE_MASK;
      map_end   = map_sum & ~arc_pkg::PAGE_MASK;
      map_ok    = ({2'b00, map_start} < map_end) && (map_start >= base_ff) &&
                  (map_end <= {2'b00, top_ff});
      range_end = {1'b0, req_addr} + {1'b0, req_length};
      range_ok  = ({1'b0, req_addr} < range_end) && (req_addr >= base_ff) &&
                  (range_end <= {1'b0, top_ff});

      job.kind         = arc_pkg::arc_kind_type'(req_kind);
      job.addr         = req_addr;
      job.map_start    = map_start;
      job.map_end      = map_end[arc_pkg::ADDR_W-1:0];
      job.range_end    = range_end;
      job.ok           = (req_kind == arc_pkg::KIND_MAP) ? map_ok : range_ok;
      job.flags        = req_flags;
      job.fault_code   = req_fault_code;
      job.write_access = req_write_access;
   end

endmodule

FILE: src/arc_fifo.sv
// Two-entry item queue between front and back end.
// Uses arc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arc_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  arc_pkg::arc_job_type push_job,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output arc_pkg::arc_job_type pop_job
);

   arc_pkg::arc_job_type        data_ff [arc_pkg::QUEUE_DEPTH];
   logic [arc_pkg::QPTR_W-1:0]  wptr_ff, wptr_in;
   logic [arc_pkg::QPTR_W-1:0]  rptr_ff, rptr_in;
   logic [arc_pkg::QCNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      full      = (cnt_ff == arc_pkg::QCNT_W'(arc_pkg::QUEUE_DEPTH));
      pop_valid = (cnt_ff != '0);
      pop_job   = data_ff[rptr_ff];
      wptr_in   = wptr_ff;
      rptr_in   = rptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wptr_in = (wptr_ff == arc_pkg::QPTR_W'(arc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == arc_pkg::QPTR_W'(arc_pkg::QUEUE_DEPTH - 1)) ? '0 :
                   rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wptr_ff] <= push_job;
      end
   end

   `ASSERT_CLK(a_cnt_bound, clock, reset, cnt_ff <= arc_pkg::QCNT_W'(arc_pkg::QUEUE_DEPTH), "queue count overflow")
   `ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `ASSERT_NEVER(a_pop_empty, clock, reset, pop && !pop_valid, "pop from empty queue")

endmodule

FILE: src/arc_back.sv
// Back end: region table in RAM, scan/shift sequencer, fault counter and
// result register. Uses arc_pkg, arc_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module arc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   input  arc_pkg::arc_job_type job,
   output logic                 job_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic                 rsp_found,
   output logic [31:0]          rsp_region_start,
   output logic [31:0]          rsp_region_end,
   output logic [3:0]           rsp_region_flags,
   output logic                 rsp_allowed,
   output logic [2:0]           rsp_pte_perm,
   output logic [31:0]          rsp_fault_count
);

   typedef struct packed {
      logic [1:0]                 status;
      logic                       found;
      logic [arc_pkg::ADDR_W-1:0] region_start;
      logic [arc_pkg::ADDR_W-1:0] region_end;
      logic [3:0]                 region_flags;
      logic                       allowed;
      logic [2:0]                 pte_perm;
   } arc_res_type;

   arc_pkg::arc_state_type     state_ff, state_in;
   arc_pkg::arc_job_type       job_ff, job_in;
   logic [arc_pkg::CNT_W-1:0]  ridx_ff, ridx_in;
   logic [arc_pkg::CNT_W-1:0]  eidx_ff, eidx_in;
   logic [arc_pkg::CNT_W-1:0]  sh_ff, sh_in;
   logic [arc_pkg::CNT_W-1:0]  pos_ff, pos_in;
   logic [arc_pkg::CNT_W-1:0]  count_ff, count_in;
   logic                       dv_ff, dv_in;
   logic                       clash_ff, clash_in;
   logic                       follow_ff, follow_in;
   logic [arc_pkg::ADDR_W:0]   cur_ff, cur_in;
   logic [arc_pkg::ADDR_W-1:0] fault_ff, fault_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   arc_res_type                res_ff, res;
   logic [arc_pkg::ADDR_W-1:0] rfault_ff;

   logic                       wr_en;
   logic [arc_pkg::IDX_W-1:0]  wr_addr;
   logic [arc_pkg::ENTRY_W-1:0] wr_data;
   logic [arc_pkg::ENTRY_W-1:0] rd_data;

   logic [arc_pkg::ADDR_W-1:0] e_start;
   logic [arc_pkg::ADDR_W-1:0] e_end;
   logic [3:0]                 e_flags;
   logic                       issue;
   logic                       hit;
   logic                       perm;
   logic                       stack_bad;
   logic                       fault_ok;
   logic                       start_job;
   logic                       fin;
   logic                       go_shift;
   logic                       shift_done;

   arc_ram #(
      .WIDTH (arc_pkg::ENTRY_W),
      .DEPTH (arc_pkg::MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (ridx_ff[arc_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // entry under evaluation and per-kind decisions
   always_comb begin
      e_start    = rd_data[arc_pkg::ENTRY_W-1 -: arc_pkg::ADDR_W];
      e_end      = rd_data[arc_pkg::ADDR_W+3 -: arc_pkg::ADDR_W];
      e_flags    = rd_data[3:0];
      issue      = (ridx_ff < count_ff);
      hit        = ({1'b0, e_start} <= cur_ff) && (cur_ff < {1'b0, e_end});
      perm       = job_ff.write_access ? e_flags[arc_pkg::FB_WRITE] :
                   e_flags[arc_pkg::FB_READ];
      stack_bad  = job_ff.write_access && e_flags[arc_pkg::FB_STACK] &&
                   (cur_ff < ({1'b0, e_start} + arc_pkg::PAGE_SIZE));
      fault_ok   = job_ff.fault_code[arc_pkg::EC_WRITE] ? e_flags[arc_pkg::FB_WRITE] :
                   (!job_ff.fault_code[arc_pkg::EC_PRESENT] &&
                    (e_flags[arc_pkg::FB_READ] || e_flags[arc_pkg::FB_EXEC]));
      start_job  = (state_ff == arc_pkg::ST_IDLE) && !rsp_valid_ff && job_valid;
      shift_done = (sh_ff == '0) && !dv_ff;
      fin        = 1'b0;
      go_shift   = 1'b0;
      res        = '0;
      case (state_ff)
         arc_pkg::ST_SCAN: begin
            case (job_ff.kind)
               arc_pkg::KIND_MAP: begin
                  if (!job_ff.ok) begin
                     fin        = 1'b1;
                     res.status = arc_pkg::STATUS_REFUSED;
                  end else if (!dv_ff && !issue) begin
                     if (clash_ff) begin
                        fin        = 1'b1;
                        res.status = arc_pkg::STATUS_REFUSED;
                     end else if (count_ff == arc_pkg::CNT_W'(arc_pkg::MAX_REGIONS)) begin
                        fin        = 1'b1;
                        res.status = arc_pkg::STATUS_FULL;
                     end else begin
                        go_shift = 1'b1;
                     end
                  end
               end
               arc_pkg::KIND_FIND, arc_pkg::KIND_FAULT: begin
                  if (dv_ff && hit) begin
                     fin              = 1'b1;
                     res.found        = 1'b1;
                     res.region_start = e_start;
                     res.region_end   = e_end;
                     res.region_flags = e_flags;
                     if (job_ff.kind == arc_pkg::KIND_FAULT) begin
                        res.allowed = fault_ok;
                        res.status  = fault_ok ? arc_pkg::STATUS_OK :
                                      arc_pkg::STATUS_REFUSED;
                        if (fault_ok) begin
                           res.pte_perm = arc_pkg::PERM_USER |
                              (e_flags[arc_pkg::FB_WRITE] ? arc_pkg::PERM_WRITE : 3'd0);
                        end
                     end
                  end else if (!dv_ff && !issue) begin
                     fin        = 1'b1;
                     res.status = arc_pkg::STATUS_REFUSED;
                  end
               end
               arc_pkg::KIND_RANGE: begin
                  res.status = arc_pkg::STATUS_REFUSED;
                  if (!job_ff.ok) begin
                     fin = 1'b1;
                  end else if (dv_ff) begin
                     if (hit) begin
                        if (!perm || stack_bad) begin
                           fin = 1'b1;
                        end else if ({1'b0, e_end} >= job_ff.range_end) begin
                           fin         = 1'b1;
                           res.status  = arc_pkg::STATUS_OK;
                           res.allowed = 1'b1;
                        end
                     end else if (follow_ff) begin
                        // sorted table: only the next entry can continue the run
                        fin = 1'b1;
                     end
                  end else if (!issue) begin
                     fin = 1'b1;
                  end
               end
               default: begin
                  fin        = 1'b1;
                  res.status = arc_pkg::STATUS_REFUSED;
               end
            endcase
         end
         arc_pkg::ST_PUT: begin
            fin              = 1'b1;
            res.status       = arc_pkg::STATUS_OK;
            res.region_start = job_ff.map_start;
            res.region_end   = job_ff.map_end;
            res.region_flags = job_ff.flags;
         end
         default: begin
            fin = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arc_pkg::ST_IDLE: begin
            if (start_job) begin
               state_in = arc_pkg::ST_SCAN;
            end
         end
         arc_pkg::ST_SCAN: begin
            if (fin) begin
               state_in = arc_pkg::ST_IDLE;
            end else if (go_shift) begin
               state_in = arc_pkg::ST_SHIFT;
            end
         end
         arc_pkg::ST_SHIFT: begin
            if (shift_done) begin
               state_in = arc_pkg::ST_PUT;
            end
         end
         arc_pkg::ST_PUT: begin
            state_in = arc_pkg::ST_IDLE;
         end
         default: begin
            state_in = arc_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and table writes
   always_comb begin
      job_in       = job_ff;
      ridx_in      = ridx_ff;
      eidx_in      = eidx_ff;
      sh_in        = sh_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      dv_in        = 1'b0;
      clash_in     = clash_ff;
      follow_in    = follow_ff;
      cur_in       = cur_ff;
      fault_in     = fault_ff;
      wr_en        = 1'b0;
      wr_addr      = eidx_ff[arc_pkg::IDX_W-1:0] + 1'b1;
      wr_data      = rd_data;
      job_pop      = start_job;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (fin) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         arc_pkg::ST_IDLE: begin
            if (start_job) begin
               job_in    = job;
               ridx_in   = '0;
               pos_in    = '0;
               clash_in  = 1'b0;
               follow_in = 1'b0;
               cur_in    = {1'b0, job.addr};
               if (job.kind == arc_pkg::KIND_FAULT) begin
                  fault_in = fault_ff + 1'b1;
               end
            end
         end
         arc_pkg::ST_SCAN: begin
            if (go_shift) begin
               // move entries pos..count-1 up by one, top first
               ridx_in = count_ff - 1'b1;
               sh_in   = count_ff - pos_ff;
            end else if (!fin) begin
               dv_in   = issue;
               eidx_in = ridx_ff;
               if (issue) begin
                  ridx_in = ridx_ff + 1'b1;
               end
               if (dv_ff) begin
                  if ((job_ff.map_start < e_end) && (e_start < job_ff.map_end)) begin
                     clash_in = 1'b1;
                  end
                  if (e_start <= job_ff.map_start) begin
                     pos_in = eidx_ff + 1'b1;
                  end
                  if (hit) begin
                     cur_in    = {1'b0, e_end};
                     follow_in = 1'b1;
                  end
               end
            end
         end
         arc_pkg::ST_SHIFT: begin
            dv_in   = (sh_ff != '0);
            eidx_in = ridx_ff;
            if (sh_ff != '0) begin
               ridx_in = ridx_ff - 1'b1;
               sh_in   = sh_ff - 1'b1;
            end
            wr_en = dv_ff;
         end
         arc_pkg::ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff[arc_pkg::IDX_W-1:0];
            wr_data  = {job_ff.map_start, job_ff.map_end, job_ff.flags};
            count_in = count_ff + 1'b1;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= arc_pkg::ST_IDLE;
         count_ff     <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      ridx_ff   <= ridx_in;
      eidx_ff   <= eidx_in;
      sh_ff     <= sh_in;
      pos_ff    <= pos_in;
      clash_ff  <= clash_in;
      follow_ff <= follow_in;
      cur_ff    <= cur_in;
      if (fin) begin
         res_ff    <= res;
         rfault_ff <= fault_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = res_ff.status;
   assign rsp_found        = res_ff.found;
   assign rsp_region_start = res_ff.region_start;
   assign rsp_region_end   = res_ff.region_end;
   assign rsp_region_flags = res_ff.region_flags;
   assign rsp_allowed      = res_ff.allowed;
   assign rsp_pte_perm     = res_ff.pte_perm;
   assign rsp_fault_count  = rfault_ff;

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= arc_pkg::CNT_W'(arc_pkg::MAX_REGIONS), "region count above table size")
   `ASSERT_CLK(a_busy_empty, clock, reset, (state_ff != arc_pkg::ST_IDLE) |-> !rsp_valid_ff, "result pending while busy")
   `ASSERT_CLK(a_put_grows, clock, reset, (state_ff == arc_pkg::ST_PUT) |=> (count_ff == $past(count_ff) + 1'b1), "insert did not grow table")
   `ASSERT_CLK(a_shift_room, clock, reset, (state_ff == arc_pkg::ST_SHIFT) |-> (count_ff < arc_pkg::CNT_W'(arc_pkg::MAX_REGIONS)), "shift into full table")

endmodule
